>>> sv/trmc_pkg.sv
// Shared types, codes and helper functions of the teach/replay mode controller.
package trmc_pkg;

  localparam int unsigned TimeoutW = 20;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned ServoW   = 8;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [TimeoutW-1:0] TimeoutReset  = TimeoutW'(3000);
  localparam logic [AngleW-1:0]   ServoMinReset = AngleW'(0);
  localparam logic [AngleW-1:0]   ServoMaxReset = AngleW'(180);

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SERVO_MIN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SERVO_MAX = 2'd2;

  localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CODE_TEACH  = 2'd1;
  localparam logic [1:0] MODE_CODE_REPLAY = 2'd2;

  typedef enum logic [2:0] {
    ACT_MOVE  = 3'd0,
    ACT_TICK  = 3'd1,
    ACT_START = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_TEACH = 3'd4,
    ACT_DONE  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_TEACH  = 3'b010,
    MODE_REPLAY = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BUSY    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               action;
    logic [ServoW-1:0]        srv_sel;
    logic signed [AngleW-1:0] delta;
    logic [AngleW-1:0]        current_angle;
  } item_t;

  typedef struct packed {
    logic [TimeoutW-1:0] idle_limit;
    logic [AngleW-1:0]   servo_min;
    logic [AngleW-1:0]   servo_max;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] move_total;
    logic              notify;
    logic              rec_clear;
    logic              play_stop;
    logic              play_start;
    logic [CountW-1:0] move_delay_ms;
    logic [AngleW-1:0] move_angle;
    logic [ServoW-1:0] move_srv;
    logic              move_valid;
    logic [1:0]        status;
    logic [1:0]        mode;
  } result_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] code;
    unique case (m)
      MODE_IDLE:   code = MODE_CODE_IDLE;
      MODE_TEACH:  code = MODE_CODE_TEACH;
      MODE_REPLAY: code = MODE_CODE_REPLAY;
      default:     code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> sv/teach_replay_mode_controller_top.sv
// Top level of the teach/replay mode controller: ports, configuration and beat registers.
// Each input beat gives exactly one result beat. A beat is taken into an input register,
// resolved combinationally against the mode state and placed in a result register when
// the result register is free or being taken; one beat per cycle is sustained as long as
// the result side keeps taking beats. The limit is the update of the mode, timer and
// counter state, which each beat reads and writes.
module teach_replay_mode_controller_top
  import trmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // srv_sel, delta, current_angle
  input  logic [2:0]          s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // mode, status, move_valid, move_srv, move_angle, move_delay_ms, play_start,
  // play_stop, rec_clear, notify, move_total, zero fill
  output logic [103:0]        m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_limit <= TimeoutReset;
      cfg_q.servo_min  <= ServoMinReset;
      cfg_q.servo_max  <= ServoMaxReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT:   cfg_q.idle_limit <= cfg_data_i[TimeoutW-1:0];
        CFG_SERVO_MIN: cfg_q.servo_min  <= cfg_data_i[AngleW-1:0];
        CFG_SERVO_MAX: cfg_q.servo_max  <= cfg_data_i[AngleW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.action        <= s_axis_tuser;
      item_q.srv_sel       <= s_axis_tdata[7:0];
      item_q.delta         <= s_axis_tdata[23:8];
      item_q.current_angle <= s_axis_tdata[39:24];
    end
  end

  trmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, res_q};

`ifndef SYNTH
  a_move_in_teach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.move_valid |-> res_q.mode == MODE_CODE_TEACH)
    else $error("move result outside teach mode");

  a_busy_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_BUSY |-> res_q.mode == MODE_CODE_REPLAY)
    else $error("busy status outside replay mode");

  a_start_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.play_start |-> res_q.mode == MODE_CODE_REPLAY && res_q.notify)
    else $error("start pulse without replay mode and notify");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.move_valid |=>
      res_q.move_total == $past(u_ctrl.count_q) + CountW'(1))
    else $error("move counter did not step by one");
`endif

endmodule

>>> sv/trmc_clamp.sv
// Angle clamp: current angle plus signed delta, limited to the servo range.
module trmc_clamp
  import trmc_pkg::*;
(
  input  logic [AngleW-1:0]        angle_i,
  input  logic signed [AngleW-1:0] delta_i,
  input  logic [AngleW-1:0]        min_i,
  input  logic [AngleW-1:0]        max_i,
  output logic [AngleW-1:0]        angle_o
);

  logic signed [AngleW+1:0] sum;
  logic signed [AngleW+1:0] lo;
  logic signed [AngleW+1:0] hi;
  logic signed [AngleW+1:0] raised;

  assign sum = $signed({2'b00, angle_i}) + (AngleW+2)'(delta_i);
  assign lo  = $signed({2'b00, min_i});
  assign hi  = $signed({2'b00, max_i});

  assign raised  = (sum < lo) ? lo : sum;
  assign angle_o = (raised > hi) ? max_i : raised[AngleW-1:0];

endmodule

>>> sv/trmc_ctrl.sv
// Mode state machine, timers and move counter with the result of one item.
module trmc_ctrl
  import trmc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  mode_e               mode_q, mode_d;
  logic                armed_q, armed_d;
  logic [TimeoutW-1:0] left_q, left_d;
  logic [TimeoutW-1:0] left_dec;
  logic [CountW-1:0]   since_q, since_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [AngleW-1:0]   clamped;

  trmc_clamp u_clamp (
    .angle_i (item_i.current_angle),
    .delta_i (item_i.delta),
    .min_i   (cfg_i.servo_min),
    .max_i   (cfg_i.servo_max),
    .angle_o (clamped)
  );

  assign left_dec = (left_q != '0) ? left_q - TimeoutW'(1) : left_q;

  always_comb begin
    mode_d  = mode_q;
    armed_d = armed_q;
    left_d  = left_q;
    since_d = since_q;
    count_d = count_q;
    res_o   = '0;
    res_o.status = ST_DONE;
    unique case (action_e'(item_i.action))
      ACT_MOVE: begin
        if (mode_q == MODE_REPLAY) begin
          res_o.status = ST_IGNORED;
        end else begin
          mode_d = MODE_TEACH;
          res_o.move_valid    = 1'b1;
          res_o.move_srv      = item_i.srv_sel;
          res_o.move_angle    = clamped;
          res_o.move_delay_ms = (mode_q == MODE_IDLE) ? '0 : since_q;
          since_d = '0;
          count_d = count_q + CountW'(1);
          armed_d = 1'b1;
          left_d  = cfg_i.idle_limit;
          res_o.notify = 1'b1;
        end
      end
      ACT_TICK: begin
        since_d = since_q + CountW'(1);
        if (armed_q) begin
          left_d = left_dec;
          if (left_dec == '0) begin
            armed_d = 1'b0;
            if (mode_q == MODE_TEACH) begin
              mode_d = MODE_REPLAY;
              res_o.play_start = 1'b1;
              res_o.notify     = 1'b1;
            end
          end
        end
      end
      ACT_START: begin
        if (mode_q == MODE_REPLAY) begin
          res_o.status = ST_BUSY;
        end else begin
          mode_d  = MODE_REPLAY;
          armed_d = 1'b0;
          left_d  = '0;
          res_o.play_start = 1'b1;
          res_o.notify     = 1'b1;
        end
      end
      ACT_STOP: begin
        mode_d  = MODE_IDLE;
        armed_d = 1'b0;
        left_d  = '0;
        res_o.play_stop = 1'b1;
        res_o.notify    = 1'b1;
      end
      ACT_TEACH: begin
        mode_d  = MODE_TEACH;
        since_d = '0;
        armed_d = 1'b1;
        left_d  = cfg_i.idle_limit;
        res_o.rec_clear = 1'b1;
        res_o.notify    = 1'b1;
      end
      ACT_DONE: begin
        mode_d = MODE_IDLE;
      end
      default: begin
      end
    endcase
    res_o.mode       = mode_code(mode_d);
    res_o.move_total = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      armed_q <= 1'b0;
      left_q  <= '0;
      since_q <= '0;
      count_q <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      armed_q <= armed_d;
      left_q  <= left_d;
      since_q <= since_d;
      count_q <= count_d;
    end
  end

endmodule
